[hdl/dsppt_pkg.sv]
// Package: codes, register indexes and payload types for the delayed switch timer.
package dsppt_pkg;

   // Switch status codes
   localparam logic [2:0] ST_NONE     = 3'd0;
   localparam logic [2:0] ST_WAIT_ON  = 3'd1;
   localparam logic [2:0] ST_ON       = 3'd2;
   localparam logic [2:0] ST_WAIT_OFF = 3'd3;
   localparam logic [2:0] ST_OFF      = 3'd4;

   // Drive modes
   localparam logic [2:0] MODE_NORMAL    = 3'd0;
   localparam logic [2:0] MODE_PULSE     = 3'd1;
   localparam logic [2:0] MODE_PULSE2    = 3'd2;
   localparam logic [2:0] MODE_PWM       = 3'd3;
   localparam logic [2:0] MODE_PULSE_OFF = 3'd4;
   localparam logic [2:0] MODE_DISABLE   = 3'd5;

   // Commands
   localparam logic [2:0] OP_EVAL      = 3'd0;
   localparam logic [2:0] OP_TURN_ON   = 3'd1;
   localparam logic [2:0] OP_TURN_OFF  = 3'd2;
   localparam logic [2:0] OP_RESET     = 3'd3;
   localparam logic [2:0] OP_READ_CHG  = 3'd4;

   // Drive edge codes
   localparam logic [1:0] EDGE_NONE = 2'd0;
   localparam logic [1:0] EDGE_ON   = 2'd1;
   localparam logic [1:0] EDGE_OFF  = 2'd2;

   // Configuration register indexes
   localparam logic [2:0] CSR_MODE      = 3'd0;
   localparam logic [2:0] CSR_DELAY_ON  = 3'd1;
   localparam logic [2:0] CSR_DELAY_OFF = 3'd2;
   localparam logic [2:0] CSR_PULSE     = 3'd3;
   localparam logic [2:0] CSR_PAUSE     = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic       level;
      logic [1:0] drive_edge;
      logic       changed;
   } rsp_type;

endpackage

[hdl/delayed_switch_pulse_pwm_timer_unit.sv]
// Top level: delayed on/off switch with pulse, double pulse and PWM drive.
// A result is registered into the output register, or into the skid while that register is held.
// Throughput: one command per cycle while req_stall is low; the state update is a single pass of
//   32-bit subtract/compare logic into the state and result registers.
// A two-entry result buffer (output register plus skid) lets one more transfer in while
//   the result side stalls. Synchronous active-high reset clears state and config.
module delayed_switch_pulse_pwm_timer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dsppt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dsppt_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);

   // Configuration registers
   logic [2:0]  mode_ff;
   logic [31:0] delay_on_ff;
   logic [31:0] delay_off_ff;
   logic [31:0] pulse_ff;
   logic [31:0] pause_ff;

   // Switch state
   logic [2:0]  status_ff,  status_in;
   logic [2:0]  saved_ff,   saved_in;
   logic        level_ff,   level_in;
   logic [31:0] on_mark_ff, on_mark_in;
   logic [31:0] off_mark_ff, off_mark_in;
   logic        change_ff,  change_in;

   // Result buffer
   logic               rsp_valid_ff;
   dsppt_pkg::rsp_type rsp_data_ff;
   logic               skid_valid_ff;
   dsppt_pkg::rsp_type skid_data_ff;

   logic               accept;
   logic               pop;
   logic [31:0]        d_on;
   logic [31:0]        d_off;
   logic               pulsing;
   logic [1:0]         edge_val;
   logic               chg_val;
   dsppt_pkg::rsp_type result;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign pop       = rsp_valid_ff && !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Modulo 2^32 elapsed times
   assign d_on    = req_data.now_ms - on_mark_ff;
   assign d_off   = req_data.now_ms - off_mark_ff;
   assign pulsing = (mode_ff == dsppt_pkg::MODE_PULSE) || (mode_ff == dsppt_pkg::MODE_PULSE2)
                    || (mode_ff == dsppt_pkg::MODE_PWM);

   // Command decode and state update
   always_comb begin
      status_in   = status_ff;
      saved_in    = saved_ff;
      level_in    = level_ff;
      on_mark_in  = on_mark_ff;
      off_mark_in = off_mark_ff;
      change_in   = change_ff;
      edge_val    = dsppt_pkg::EDGE_NONE;
      chg_val     = 1'b0;

      case (req_data.op)
         dsppt_pkg::OP_EVAL: begin
            case (status_ff)
               dsppt_pkg::ST_WAIT_ON: begin
                  if (d_on > delay_on_ff) begin
                     status_in  = dsppt_pkg::ST_ON;
                     on_mark_in = req_data.now_ms;
                     edge_val   = dsppt_pkg::EDGE_ON;
                     level_in   = 1'b1;
                  end
               end
               dsppt_pkg::ST_WAIT_OFF: begin
                  if (d_off > delay_off_ff) begin
                     status_in   = dsppt_pkg::ST_OFF;
                     off_mark_in = req_data.now_ms;
                     if (level_ff) edge_val = dsppt_pkg::EDGE_OFF;
                     level_in    = 1'b0;
                  end
               end
               dsppt_pkg::ST_ON: begin
                  if (pulsing && level_ff && (d_on > pulse_ff)) begin
                     on_mark_in = req_data.now_ms;
                     edge_val   = dsppt_pkg::EDGE_OFF;
                     level_in   = 1'b0;
                  end else if ((mode_ff == dsppt_pkg::MODE_PWM) && !level_ff
                               && (d_on > pause_ff)) begin
                     on_mark_in = req_data.now_ms;
                     edge_val   = dsppt_pkg::EDGE_ON;
                     level_in   = 1'b1;
                  end
               end
               dsppt_pkg::ST_OFF: begin
                  if ((mode_ff == dsppt_pkg::MODE_PULSE_OFF) && !level_ff) begin
                     on_mark_in = req_data.now_ms;
                     edge_val   = dsppt_pkg::EDGE_ON;
                     level_in   = 1'b1;
                  end else if ((mode_ff == dsppt_pkg::MODE_PULSE2) && !level_ff
                               && (d_on <= pause_ff)) begin
                     edge_val = dsppt_pkg::EDGE_ON;
                     level_in = 1'b1;
                  end else if ((mode_ff == dsppt_pkg::MODE_PULSE2) && level_ff
                               && (d_on > pause_ff)) begin
                     edge_val = dsppt_pkg::EDGE_OFF;
                     level_in = 1'b0;
                  end else if ((mode_ff == dsppt_pkg::MODE_PULSE_OFF) && level_ff
                               && (d_on > pulse_ff)) begin
                     on_mark_in = req_data.now_ms;
                     edge_val   = dsppt_pkg::EDGE_OFF;
                     level_in   = 1'b0;
                  end
               end
               default: ;
            endcase
            // change detection runs on the updated status
            if (saved_ff != status_in) begin
               change_in = 1'b1;
               saved_in  = status_in;
            end
         end
         dsppt_pkg::OP_TURN_ON: begin
            if ((mode_ff != dsppt_pkg::MODE_DISABLE) && (status_ff != dsppt_pkg::ST_WAIT_ON)
                && (status_ff != dsppt_pkg::ST_ON)) begin
               on_mark_in = req_data.now_ms;
               if (delay_on_ff == 32'd0) begin
                  status_in = dsppt_pkg::ST_ON;
                  edge_val  = dsppt_pkg::EDGE_ON;
                  level_in  = 1'b1;
               end else begin
                  status_in = dsppt_pkg::ST_WAIT_ON;
               end
            end
         end
         dsppt_pkg::OP_TURN_OFF: begin
            if ((mode_ff != dsppt_pkg::MODE_DISABLE) && (status_ff != dsppt_pkg::ST_WAIT_OFF)
                && (status_ff != dsppt_pkg::ST_OFF)) begin
               off_mark_in = req_data.now_ms;
               if (delay_off_ff == 32'd0) begin
                  status_in = dsppt_pkg::ST_OFF;
                  if (level_ff) edge_val = dsppt_pkg::EDGE_OFF;
                  level_in  = 1'b0;
               end else begin
                  status_in = dsppt_pkg::ST_WAIT_OFF;
               end
            end
         end
         dsppt_pkg::OP_RESET: begin
            status_in = dsppt_pkg::ST_NONE;
         end
         dsppt_pkg::OP_READ_CHG: begin
            chg_val   = change_ff;
            change_in = 1'b0;
         end
         default: ;
      endcase

      result.status     = status_in;
      result.level      = level_in;
      result.drive_edge = edge_val;
      result.changed    = chg_val;
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= dsppt_pkg::MODE_NORMAL;
         delay_on_ff  <= 32'd0;
         delay_off_ff <= 32'd0;
         pulse_ff     <= 32'd0;
         pause_ff     <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            dsppt_pkg::CSR_MODE:      mode_ff      <= csr_data[2:0];
            dsppt_pkg::CSR_DELAY_ON:  delay_on_ff  <= csr_data;
            dsppt_pkg::CSR_DELAY_OFF: delay_off_ff <= csr_data;
            dsppt_pkg::CSR_PULSE:     pulse_ff     <= csr_data;
            dsppt_pkg::CSR_PAUSE:     pause_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // State commits only on a command transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff   <= dsppt_pkg::ST_NONE;
         saved_ff    <= dsppt_pkg::ST_NONE;
         level_ff    <= 1'b0;
         on_mark_ff  <= 32'd0;
         off_mark_ff <= 32'd0;
         change_ff   <= 1'b0;
      end else if (accept) begin
         status_ff   <= status_in;
         saved_ff    <= saved_in;
         level_ff    <= level_in;
         on_mark_ff  <= on_mark_in;
         off_mark_ff <= off_mark_in;
         change_ff   <= change_in;
      end
   end

   // Result buffer: skid takes the new result when the output register is held
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || pop) begin
         if (skid_valid_ff) rsp_data_ff <= skid_data_ff;
         else if (accept)   rsp_data_ff <= result;
      end else if (accept) begin
         skid_data_ff <= result;
      end
   end

endmodule

[sim/delayed_switch_pulse_pwm_timer_unit_test.sv]
// Testbench for the delayed switch timer: directed and random commands checked against a local model.
module delayed_switch_pulse_pwm_timer_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Run length and shape
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 13;      // register settings in the random part
   localparam int PHASE_ITEMS = 100;     // commands per setting

   // Op codes the block must treat as no-ops
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   dsppt_pkg::req_type req_data;
   logic               rsp_valid;
   logic               rsp_stall;
   dsppt_pkg::rsp_type rsp_data;
   logic               csr_we;
   logic [2:0]         csr_index;
   logic [31:0]        csr_data;

   delayed_switch_pulse_pwm_timer_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Local copy of the switch state, updated as each command transfer is accepted
   logic [2:0]  sw_status;
   logic [2:0]  sw_saved;
   logic        sw_level;
   logic [31:0] sw_on_mark;
   logic [31:0] sw_off_mark;
   logic        sw_changed;
   logic [1:0]  sw_edge;

   // Mirror of the register file
   logic [2:0]  cfg_mode;
   logic [31:0] cfg_delay_on;
   logic [31:0] cfg_delay_off;
   logic [31:0] cfg_pulse;
   logic [31:0] cfg_pause;

   // Reports still owed by the block, oldest first
   dsppt_pkg::rsp_type switch_reports[$];
   dsppt_pkg::rsp_type want_rsp;

   bit          idle_on;
   int          stall_left;
   int          fail_count;
   int          checked_count;
   int          settings_count;
   int          on_edges;
   int          off_edges;
   int          flag_reads;
   logic [31:0] wall_ms;   // free-running time fed to the random commands

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop in case the handshake hangs
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("delayed_switch_pulse_pwm_timer_unit_test: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Switch model
   // ------------------------------------------------------------------

   // A switch-on event is always reported
   function automatic void raise_drive();
      sw_edge  = dsppt_pkg::EDGE_ON;
      sw_level = 1'b1;
   endfunction

   // A switch-off event is reported only when the output was actually high
   function automatic void drop_drive();
      if (sw_level) begin
         sw_edge = dsppt_pkg::EDGE_OFF;
      end
      sw_level = 1'b0;
   endfunction

   // Applies one command to the local state and returns the report it should produce
   function automatic dsppt_pkg::rsp_type advance_switch(dsppt_pkg::req_type cmd);
      dsppt_pkg::rsp_type r;
      logic [31:0]        since_on;
      logic [31:0]        since_off;
      logic               pulsing;
      logic               chg;
      // differences wrap modulo 2^32, taken before any mark moves
      since_on  = cmd.now_ms - sw_on_mark;
      since_off = cmd.now_ms - sw_off_mark;
      pulsing   = (cfg_mode == dsppt_pkg::MODE_PULSE) || (cfg_mode == dsppt_pkg::MODE_PULSE2) ||
                  (cfg_mode == dsppt_pkg::MODE_PWM);
      chg       = 1'b0;
      sw_edge   = dsppt_pkg::EDGE_NONE;
      case (cmd.op)
         dsppt_pkg::OP_EVAL: begin
            case (sw_status)
               dsppt_pkg::ST_WAIT_ON: begin
                  if (since_on > cfg_delay_on) begin
                     sw_status  = dsppt_pkg::ST_ON;
                     sw_on_mark = cmd.now_ms;
                     raise_drive();
                  end
               end
               dsppt_pkg::ST_WAIT_OFF: begin
                  if (since_off > cfg_delay_off) begin
                     sw_status   = dsppt_pkg::ST_OFF;
                     sw_off_mark = cmd.now_ms;
                     drop_drive();
                  end
               end
               dsppt_pkg::ST_ON: begin
                  // pulse high time ends, or pwm low time ends
                  if (pulsing && sw_level && since_on > cfg_pulse) begin
                     sw_on_mark = cmd.now_ms;
                     drop_drive();
                  end else if (cfg_mode == dsppt_pkg::MODE_PWM && !sw_level
                               && since_on > cfg_pause) begin
                     sw_on_mark = cmd.now_ms;
                     raise_drive();
                  end
               end
               dsppt_pkg::ST_OFF: begin
                  // second pulse of double pulse, or the single pulse fired at off
                  if (cfg_mode == dsppt_pkg::MODE_PULSE_OFF && !sw_level) begin
                     sw_on_mark = cmd.now_ms;
                     raise_drive();
                  end else if (cfg_mode == dsppt_pkg::MODE_PULSE2 && !sw_level
                               && since_on <= cfg_pause) begin
                     raise_drive();
                  end else if (cfg_mode == dsppt_pkg::MODE_PULSE2 && sw_level
                               && since_on > cfg_pause) begin
                     drop_drive();
                  end else if (cfg_mode == dsppt_pkg::MODE_PULSE_OFF && sw_level
                               && since_on > cfg_pulse) begin
                     sw_on_mark = cmd.now_ms;
                     drop_drive();
                  end
               end
               default: begin
               end
            endcase
            // only evaluate latches a status change
            if (sw_saved != sw_status) begin
               sw_changed = 1'b1;
               sw_saved   = sw_status;
            end
         end
         dsppt_pkg::OP_TURN_ON: begin
            if (cfg_mode != dsppt_pkg::MODE_DISABLE && sw_status != dsppt_pkg::ST_WAIT_ON
                && sw_status != dsppt_pkg::ST_ON) begin
               sw_on_mark = cmd.now_ms;
               if (cfg_delay_on == 32'd0) begin
                  sw_status = dsppt_pkg::ST_ON;
                  raise_drive();
               end else begin
                  sw_status = dsppt_pkg::ST_WAIT_ON;
               end
            end
         end
         dsppt_pkg::OP_TURN_OFF: begin
            if (cfg_mode != dsppt_pkg::MODE_DISABLE && sw_status != dsppt_pkg::ST_WAIT_OFF
                && sw_status != dsppt_pkg::ST_OFF) begin
               sw_off_mark = cmd.now_ms;
               if (cfg_delay_off == 32'd0) begin
                  sw_status = dsppt_pkg::ST_OFF;
                  drop_drive();
               end else begin
                  sw_status = dsppt_pkg::ST_WAIT_OFF;
               end
            end
         end
         dsppt_pkg::OP_RESET: begin
            sw_status = dsppt_pkg::ST_NONE;
         end
         dsppt_pkg::OP_READ_CHG: begin
            chg        = sw_changed;
            sw_changed = 1'b0;
         end
         default: begin
         end
      endcase
      r.status     = sw_status;
      r.level      = sw_level;
      r.drive_edge = sw_edge;
      r.changed    = chg;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // Sends one command; may first drop valid for a random burst. Valid is left
   // high afterwards so back-to-back commands go out without a bubble.
   task automatic issue_command(input logic [2:0] op, input logic [31:0] now);
      dsppt_pkg::req_type cmd;
      dsppt_pkg::rsp_type want;
      cmd.op     = op;
      cmd.now_ms = now;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_data  <= cmd;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      // transfer taken at this edge
      want = advance_switch(cmd);
      if (want.drive_edge == dsppt_pkg::EDGE_ON) on_edges++;
      if (want.drive_edge == dsppt_pkg::EDGE_OFF) off_edges++;
      if (want.changed) flag_reads++;
      switch_reports.push_back(want);
   endtask

   // Stops sending and waits until every owed report has been taken
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (switch_reports.size() != 0) @(posedge clock);
   endtask

   // One register write; leaves csr_we high so writes can run back to back
   task automatic put_reg(input logic [2:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      case (index)
         dsppt_pkg::CSR_MODE:      cfg_mode      = value[2:0];
         dsppt_pkg::CSR_DELAY_ON:  cfg_delay_on  = value;
         dsppt_pkg::CSR_DELAY_OFF: cfg_delay_off = value;
         dsppt_pkg::CSR_PULSE:     cfg_pulse     = value;
         dsppt_pkg::CSR_PAUSE:     cfg_pause     = value;
         default: begin
         end
      endcase
   endtask

   // Rewrites every register, only once the block has gone quiet
   task automatic load_config(input logic [2:0] mode, input logic [31:0] d_on,
                              input logic [31:0] d_off, input logic [31:0] pulse,
                              input logic [31:0] pause);
      wait_idle();
      put_reg(dsppt_pkg::CSR_MODE, {29'd0, mode});
      put_reg(dsppt_pkg::CSR_DELAY_ON, d_on);
      put_reg(dsppt_pkg::CSR_DELAY_OFF, d_off);
      put_reg(dsppt_pkg::CSR_PULSE, pulse);
      put_reg(dsppt_pkg::CSR_PAUSE, pause);
      csr_we <= 1'b0;
      settings_count++;
   endtask

   // Timing register value: mostly short so delays and pulses expire often
   function automatic logic [31:0] pick_ms();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 32'd0;
      if (pick == 1) return 32'hFFFF_FFFF;
      if (pick == 2) return $urandom;
      return $urandom_range(1, 12);
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Zero delays, normal mode: every command, repeats, spare op codes, change flag
   task automatic test_basic_commands();
      load_config(dsppt_pkg::MODE_NORMAL, 32'd0, 32'd0, 32'd0, 32'd0);
      issue_command(dsppt_pkg::OP_READ_CHG, 32'd0);         // flag clear after reset
      issue_command(OP_UNUSED_FIRST, 32'd0);
      issue_command(OP_UNUSED_LAST, 32'hFFFF_FFFF);
      issue_command(dsppt_pkg::OP_TURN_ON, 32'hFFFF_FFFF);  // immediate switch on
      issue_command(dsppt_pkg::OP_TURN_ON, 32'd1);          // repeat is ignored
      issue_command(dsppt_pkg::OP_EVAL, 32'd2);             // latches the change
      issue_command(dsppt_pkg::OP_READ_CHG, 32'd3);
      issue_command(dsppt_pkg::OP_TURN_OFF, 32'd5);         // immediate switch off with edge
      issue_command(dsppt_pkg::OP_TURN_OFF, 32'd6);         // repeat is ignored
      issue_command(dsppt_pkg::OP_RESET, 32'd7);
      issue_command(dsppt_pkg::OP_TURN_OFF, 32'd8);         // off while already low: no edge
      issue_command(dsppt_pkg::OP_EVAL, 32'd9);
      issue_command(dsppt_pkg::OP_READ_CHG, 32'd10);
   endtask

   // On delay across the 2^32 wrap, and an off delay that can never expire
   task automatic test_delays_and_wrap();
      load_config(dsppt_pkg::MODE_NORMAL, 32'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
      issue_command(dsppt_pkg::OP_TURN_ON, 32'hFFFF_FFFE);
      issue_command(dsppt_pkg::OP_EVAL, 32'd3);             // exactly the delay: still waiting
      issue_command(dsppt_pkg::OP_EVAL, 32'd4);             // one past: switches on
      issue_command(dsppt_pkg::OP_TURN_OFF, 32'd10);
      issue_command(dsppt_pkg::OP_EVAL, 32'd9);             // largest difference, still waiting
   endtask

   // Disabled mode ignores on/off but evaluate and reset still act
   task automatic test_disabled_mode();
      load_config(dsppt_pkg::MODE_DISABLE, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0);
      issue_command(dsppt_pkg::OP_TURN_ON, 32'd20);
      issue_command(dsppt_pkg::OP_TURN_OFF, 32'd21);
      issue_command(dsppt_pkg::OP_EVAL, 32'd0);
      issue_command(dsppt_pkg::OP_RESET, 32'd22);
      issue_command(dsppt_pkg::OP_EVAL, 32'd23);
      issue_command(dsppt_pkg::OP_READ_CHG, 32'd24);
   endtask

   // Random command streams over a series of register settings. Time mostly
   // creeps forward in small steps so delays, pulses and pwm periods expire.
   task automatic test_random_phases();
      int         pick;
      logic [2:0] op;
      logic [2:0] mode_code;
      wall_ms = $urandom;
      for (int phase = 0; phase < PHASES; phase++) begin
         // no idling in the closing phases, and one quiet phase in every four
         idle_on   = (phase < PHASES - 3) && (phase % 4 != 3);
         mode_code = (phase < 8) ? 3'(phase) : 3'($urandom_range(0, 7));
         load_config(mode_code, pick_ms(), pick_ms(), pick_ms(), pick_ms());
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // sometimes let the block run dry in mid stream
            if (n == PHASE_ITEMS / 2 && $urandom_range(0, 2) == 0) wait_idle();
            pick = $urandom_range(0, 99);
            if (pick == 0) wall_ms = $urandom;
            else if (pick == 1) wall_ms = 32'hFFFF_FFF8 + $urandom_range(0, 7);
            else wall_ms += $urandom_range(0, 4);
            pick = $urandom_range(0, 99);
            if (pick < 50) op = dsppt_pkg::OP_EVAL;
            else if (pick < 64) op = dsppt_pkg::OP_TURN_ON;
            else if (pick < 78) op = dsppt_pkg::OP_TURN_OFF;
            else if (pick < 84) op = dsppt_pkg::OP_RESET;
            else if (pick < 95) op = dsppt_pkg::OP_READ_CHG;
            else op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            issue_command(op, wall_ms);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Result side: random stall bursts and the per-field compare
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (switch_reports.size() == 0) begin
            $error("report with no command outstanding: %p", rsp_data);
            fail_count++;
         end else begin
            want_rsp = switch_reports.pop_front();
            checked_count++;
            if (rsp_data.status !== want_rsp.status) begin
               $error("status: expected %0d, got %0d", want_rsp.status, rsp_data.status);
               fail_count++;
            end
            if (rsp_data.level !== want_rsp.level) begin
               $error("level: expected %0d, got %0d", want_rsp.level, rsp_data.level);
               fail_count++;
            end
            if (rsp_data.drive_edge !== want_rsp.drive_edge) begin
               $error("drive_edge: expected %0d, got %0d",
                      want_rsp.drive_edge, rsp_data.drive_edge);
               fail_count++;
            end
            if (rsp_data.changed !== want_rsp.changed) begin
               $error("changed: expected %0d, got %0d", want_rsp.changed, rsp_data.changed);
               fail_count++;
            end
         end
      end
      // random stall bursts while idling is allowed
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (!reset && idle_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 14) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      // model state matches the block after reset
      sw_status      = dsppt_pkg::ST_NONE;
      sw_saved       = dsppt_pkg::ST_NONE;
      sw_level       = 1'b0;
      sw_on_mark     = 32'd0;
      sw_off_mark    = 32'd0;
      sw_changed     = 1'b0;
      sw_edge        = dsppt_pkg::EDGE_NONE;
      cfg_mode       = dsppt_pkg::MODE_NORMAL;
      cfg_delay_on   = 32'd0;
      cfg_delay_off  = 32'd0;
      cfg_pulse      = 32'd0;
      cfg_pause      = 32'd0;
      idle_on        = 1'b1;
      stall_left     = 0;
      fail_count     = 0;
      checked_count  = 0;
      settings_count = 0;
      on_edges       = 0;
      off_edges      = 0;
      flag_reads     = 0;
      wall_ms        = 32'd0;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_stall <= 1'b0;
      csr_we    <= 1'b0;
      csr_index <= dsppt_pkg::CSR_MODE;
      csr_data  <= 32'd0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_basic_commands();
      test_delays_and_wrap();
      test_disabled_mode();
      test_random_phases();

      // drain, then keep the clock running so any stray report can show
      wait_idle();
      repeat (20) @(posedge clock);

      $display("covered %0d commands over %0d register settings, all eight modes and op codes",
               checked_count, settings_count);
      $display("saw %0d switch-on and %0d switch-off edges, %0d change flag reads set",
               on_edges, off_edges, flag_reads);
      if (fail_count == 0 && switch_reports.size() == 0) begin
         $display("delayed_switch_pulse_pwm_timer_unit_test: PASS");
      end else begin
         $display("delayed_switch_pulse_pwm_timer_unit_test: FAIL");
      end
      $finish;
   end

endmodule
